// ----- rtl/sacs_pkg.sv -----
// ----------------------------------------------------------------------------
// sacs_pkg
// Shared types, sizes and helpers for the subarray OR coverage scorer.
// ----------------------------------------------------------------------------
package sacs_pkg;

   localparam int MAX_SYMBOLS = 12;
   localparam int LIST_DEPTH  = 13;
   localparam int STAMP_BITS  = 8;

   localparam int K_W        = 4;
   localparam int LIST_IDX_W = $clog2(LIST_DEPTH);
   localparam int LIST_CNT_W = $clog2(LIST_DEPTH + 1);
   localparam int SCORE_W    = 19;
   localparam int COVER_W    = 13;
   localparam int COUNT_W    = 12;
   localparam int RANK_W     = $clog2(MAX_SYMBOLS + 1);
   localparam int WEIGHT_W   = 7;

   localparam logic [SCORE_W-1:0] SCORE_MAX = '1;
   localparam logic [COVER_W-1:0] COVER_MAX = '1;
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   localparam logic [WEIGHT_W-1:0] WEIGHT_BASE    = WEIGHT_W'(1);
   localparam logic [WEIGHT_W-1:0] WEIGHT_CENTRAL = WEIGHT_W'(100);
   localparam logic [WEIGHT_W-1:0] WEIGHT_NEAR    = WEIGHT_W'(8);

   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic CSR_SYMBOL_COUNT = 1'b0;

   typedef enum logic [2:0] {
      ST_INIT_CLEAR,
      ST_IDLE,
      ST_LOAD,
      ST_WRAP_CLEAR,
      ST_WALK,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic load;
      logic sweep;
      logic step;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic wrap_pending;
      logic sweep_last;
      logic walk_last;
      logic out_free;
   } status_type;

   function automatic logic [K_W-1:0] eff_k(input logic [K_W-1:0] k);
      logic [K_W-1:0] r;
      r = k;
      if (k == '0) r = K_W'(1);
      if (k > K_W'(MAX_SYMBOLS)) r = K_W'(MAX_SYMBOLS);
      return r;
   endfunction

   function automatic logic [MAX_SYMBOLS-1:0] k_mask(input logic [K_W-1:0] k);
      logic [MAX_SYMBOLS:0] t;
      t = ({{MAX_SYMBOLS{1'b0}}, 1'b1} << k) - 1'b1;
      return t[MAX_SYMBOLS-1:0];
   endfunction

   function automatic logic [RANK_W-1:0] ones(input logic [MAX_SYMBOLS-1:0] v);
      logic [RANK_W-1:0] n;
      n = '0;
      for (int b = 0; b < MAX_SYMBOLS; b++) n = n + RANK_W'(v[b]);
      return n;
   endfunction

   function automatic logic [WEIGHT_W-1:0] mask_weight(input logic [RANK_W-1:0] r,
                                                      input logic [K_W-1:0] k);
      logic [K_W:0]        h;
      logic [K_W:0]        rr;
      logic                central;
      logic                near;
      logic [WEIGHT_W-1:0] w;
      h       = {1'b0, k} >> 1;
      rr      = (K_W + 1)'(r);
      central = (rr == h) || (k[0] && (rr == h + 1'b1));
      near    = (rr + 1'b1 == h) || (rr == {1'b0, k} - h + 1'b1);
      w       = WEIGHT_BASE;
      if (central) w = w + WEIGHT_CENTRAL;
      if (near) w = w + WEIGHT_NEAR;
      return w;
   endfunction

endpackage

// ----- rtl/sacs_ctrl.sv -----
// ----------------------------------------------------------------------------
// sacs_ctrl
// Sequencer: stamp clearing sweeps, item load, list walk, drain and result.
// ----------------------------------------------------------------------------
module sacs_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  sacs_pkg::status_type   status,
   output sacs_pkg::cmd_type      cmd
);

   sacs_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sacs_pkg::ST_INIT_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sacs_pkg::ST_INIT_CLEAR: begin
            if (status.sweep_last) state_in = sacs_pkg::ST_IDLE;
         end
         sacs_pkg::ST_IDLE: begin
            if (req_tvalid) state_in = sacs_pkg::ST_LOAD;
         end
         sacs_pkg::ST_LOAD: begin
            state_in = status.wrap_pending ? sacs_pkg::ST_WRAP_CLEAR : sacs_pkg::ST_WALK;
         end
         sacs_pkg::ST_WRAP_CLEAR: begin
            if (status.sweep_last) state_in = sacs_pkg::ST_WALK;
         end
         sacs_pkg::ST_WALK: begin
            if (status.walk_last) state_in = sacs_pkg::ST_DRAIN;
         end
         sacs_pkg::ST_DRAIN: begin
            state_in = sacs_pkg::ST_FINISH;
         end
         sacs_pkg::ST_FINISH: begin
            if (status.out_free) state_in = sacs_pkg::ST_IDLE;
         end
         default: begin
            state_in = sacs_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         sacs_pkg::ST_INIT_CLEAR, sacs_pkg::ST_WRAP_CLEAR: begin
            cmd.sweep = 1'b1;
         end
         sacs_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         sacs_pkg::ST_WALK: begin
            cmd.step = 1'b1;
         end
         sacs_pkg::ST_FINISH: begin
            cmd.finish = status.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

// ----- rtl/sacs_datapath.sv -----
// ----------------------------------------------------------------------------
// sacs_datapath
// OR list banks, epoch stamp store, weight scoring and the result register.
// ----------------------------------------------------------------------------
module sacs_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [sacs_pkg::K_W-1:0]            symbol_count,
   input  logic [sacs_pkg::MAX_SYMBOLS-1:0]    item_mask,
   input  logic                                start_sequence,
   input  sacs_pkg::cmd_type                   cmd,
   output sacs_pkg::status_type                status,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [sacs_pkg::SCORE_W-1:0]        running_score,
   output logic [sacs_pkg::COUNT_W-1:0]        covered_count,
   output logic                                all_covered
);

   localparam int MW   = sacs_pkg::MAX_SYMBOLS;
   localparam int EW   = sacs_pkg::STAMP_BITS;
   localparam int IW   = sacs_pkg::LIST_IDX_W;
   localparam int CW   = sacs_pkg::LIST_CNT_W;
   localparam int SW   = sacs_pkg::SCORE_W;
   localparam int VW   = sacs_pkg::COVER_W;
   localparam int KW   = sacs_pkg::K_W;
   localparam int SIZE = 1 << MW;

   logic [EW-1:0] stamp_mem [SIZE];
   logic [EW-1:0] stamp_rd_ff;
   logic [MW-1:0] sweep_ff;

   logic [MW-1:0] list_ff [2][sacs_pkg::LIST_DEPTH];
   logic          bank_ff;
   logic [CW-1:0] len_ff;
   logic [CW-1:0] idx_ff;
   logic [CW-1:0] n_ff;
   logic [MW-1:0] last_ff;

   logic [MW-1:0] value_ff;
   logic [MW-1:0] kmask_ff;
   logic [KW-1:0] k_ff;
   logic [EW-1:0] epoch_ff;
   logic          wrap_ff;
   logic [SW-1:0] score_ff;
   logic [VW-1:0] cover_ff;

   logic          b_valid_ff;
   logic [MW-1:0] b_cand_ff;

   logic          rsp_valid_ff;
   logic [SW-1:0] rsp_score_ff;
   logic [sacs_pkg::COUNT_W-1:0] rsp_count_ff;
   logic          rsp_full_ff;

   logic [KW-1:0] k_now;
   logic [MW-1:0] kmask_now;
   logic [CW-1:0] rd_idx;
   logic [MW-1:0] list_rd;
   logic [MW-1:0] cand;
   logic          append;
   logic          b_new;
   logic [sacs_pkg::WEIGHT_W-1:0] weight;
   logic [SW:0]   score_sum;
   logic [EW-1:0] epoch_inc;

   assign k_now     = sacs_pkg::eff_k(symbol_count);
   assign kmask_now = sacs_pkg::k_mask(k_now);
   assign epoch_inc = epoch_ff + 1'b1;

   assign rd_idx  = idx_ff - 1'b1;
   assign list_rd = list_ff[bank_ff][rd_idx[IW-1:0]];
   assign cand    = (idx_ff == '0) ? value_ff : ((list_rd | value_ff) & kmask_ff);
   assign append  = cmd.step && ((idx_ff == '0) ||
                    ((cand != last_ff) && (n_ff < CW'(sacs_pkg::LIST_DEPTH))));

   assign b_new     = b_valid_ff && (b_cand_ff != '0) && (stamp_rd_ff != epoch_ff);
   assign weight    = sacs_pkg::mask_weight(sacs_pkg::ones(b_cand_ff), k_ff);
   assign score_sum = {1'b0, score_ff} + (SW + 1)'(weight);

   // stamp store: clearing sweep or stamp write, registered read
   always_ff @(posedge clock) begin
      if (cmd.sweep) begin
         stamp_mem[sweep_ff] <= '0;
      end else if (b_new) begin
         stamp_mem[b_cand_ff] <= epoch_ff;
      end
      stamp_rd_ff <= stamp_mem[cand];
   end

   always_ff @(posedge clock) begin
      if (append) begin
         list_ff[~bank_ff][n_ff[IW-1:0]] <= cand;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff     <= '0;
         bank_ff      <= 1'b0;
         len_ff       <= '0;
         idx_ff       <= '0;
         n_ff         <= '0;
         epoch_ff     <= '0;
         wrap_ff      <= 1'b0;
         score_ff     <= '0;
         cover_ff     <= '0;
         b_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.sweep) sweep_ff <= sweep_ff + 1'b1;
         if (cmd.load) begin
            idx_ff  <= '0;
            n_ff    <= '0;
            wrap_ff <= 1'b0;
            if (start_sequence) begin
               len_ff   <= '0;
               score_ff <= '0;
               cover_ff <= '0;
               if (epoch_inc == '0) begin
                  epoch_ff <= EW'(1);
                  wrap_ff  <= 1'b1;
               end else begin
                  epoch_ff <= epoch_inc;
               end
            end
         end
         if (cmd.step) idx_ff <= idx_ff + 1'b1;
         if (append) n_ff <= n_ff + 1'b1;
         b_valid_ff <= append;
         if (b_new) begin
            score_ff <= (score_sum > (SW + 1)'(sacs_pkg::SCORE_MAX)) ?
                        sacs_pkg::SCORE_MAX : score_sum[SW-1:0];
            if (cover_ff != sacs_pkg::COVER_MAX) cover_ff <= cover_ff + 1'b1;
         end
         if (cmd.finish) begin
            bank_ff <= ~bank_ff;
            len_ff  <= n_ff;
         end
         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         value_ff <= item_mask & kmask_now;
         kmask_ff <= kmask_now;
         k_ff     <= k_now;
      end
      if (append) last_ff <= cand;
      b_cand_ff <= cand;
      if (cmd.finish) begin
         rsp_score_ff <= score_ff;
         rsp_count_ff <= (cover_ff > VW'(sacs_pkg::COUNT_MAX)) ?
                         sacs_pkg::COUNT_MAX : cover_ff[sacs_pkg::COUNT_W-1:0];
         rsp_full_ff  <= (cover_ff == {1'b0, kmask_ff});
      end
   end

   assign status.wrap_pending = wrap_ff;
   assign status.sweep_last   = (sweep_ff == '1);
   assign status.walk_last    = (idx_ff == len_ff);
   assign status.out_free     = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid    = rsp_valid_ff;
   assign running_score = rsp_score_ff;
   assign covered_count = rsp_count_ff;
   assign all_covered   = rsp_full_ff;

endmodule

// ----- rtl/subarray_or_coverage_scorer.sv -----
// ----------------------------------------------------------------------------
// subarray_or_coverage_scorer
// Scores the distinct ORs of all runs of a mask stream ending at each item.
// ----------------------------------------------------------------------------
// Input words arrive on req_*: tdata carries the item mask, tuser the flag
// that opens a new sequence (clearing list, score and coverage). Each input
// word yields exactly one result word on rsp_*: running score, covered mask
// count and the full-coverage flag.
// An item runs from accept to the next accept in this order: the accept
// cycle, the load cycle, one list-walk step per candidate OR (the item
// itself plus one per entry of the OR list left by the previous item: none
// when the item opens a new sequence, at most LIST_DEPTH, 13) through the
// stamp store read-modify-write pipeline, the drain cycle and the result
// cycle. When a new sequence wraps the 8-bit epoch, a clearing pass over all
// 4096 stamp entries runs before that item's walk.
// After reset a clearing pass over all 4096 stamp store entries runs with
// req_tready low; csr writes and reads are served throughout.
// The result sits in an output register; if rsp_tready stays low, the next
// item is still accepted and worked, and holds only at its result cycle.
// symbol_count lies at csr address 0 and resets to 8.
// ----------------------------------------------------------------------------
module subarray_or_coverage_scorer (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [sacs_pkg::REQ_DATA_W-1:0]      req_tdata,  // item_mask[11:0]
   input  logic                                 req_tuser,  // start_sequence
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // running_score[18:0], covered_count[30:19], all_covered[31]
   output logic [sacs_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [sacs_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [sacs_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [sacs_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                 csr_pready
);

   sacs_pkg::cmd_type    cmd;
   sacs_pkg::status_type status;

   logic [sacs_pkg::K_W-1:0]     symbol_count_ff;
   logic [sacs_pkg::SCORE_W-1:0] running_score;
   logic [sacs_pkg::COUNT_W-1:0] covered_count;
   logic                         all_covered;
   logic                         csr_hit;

   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[2] == sacs_pkg::CSR_SYMBOL_COUNT);

   always_ff @(posedge clock) begin
      if (reset) begin
         symbol_count_ff <= sacs_pkg::K_W'(8);
      end else if (csr_psel && csr_penable && csr_pwrite && csr_hit) begin
         symbol_count_ff <= csr_pwdata[sacs_pkg::K_W-1:0];
      end
   end

   assign csr_prdata = csr_hit ? sacs_pkg::CSR_DATA_W'(symbol_count_ff) : '0;

   sacs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   sacs_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .symbol_count   (symbol_count_ff),
      .item_mask      (req_tdata[sacs_pkg::MAX_SYMBOLS-1:0]),
      .start_sequence (req_tuser),
      .cmd            (cmd),
      .status         (status),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .running_score  (running_score),
      .covered_count  (covered_count),
      .all_covered    (all_covered)
   );

   assign rsp_tdata = {all_covered, covered_count, running_score};

endmodule

// ----- test/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the subarray OR coverage scorer.
// ----------------------------------------------------------------------------
// Mask words go in on req_*, with random bursts and gaps. Each accepted word
// runs through a behavioral scorer that keeps its own OR list, epoch-stamped
// seen store, totals and symbol_count. The scorer queues the expected result
// word. A checker pops that queue on every rsp_* handshake and compares
// score, covered count and the full flag. The receiver stalls on its own
// changing pattern, and once holds off long enough to back up the block.
// Tests: items before any start, rank weights, symbol_count extremes, full
// coverage, back-pressure, epoch wrap, then random sequences over several
// symbol counts.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int SETTLE_TICKS = 40;
   localparam int STORE_SIZE   = 1 << sacs_pkg::MAX_SYMBOLS;
   localparam logic [sacs_pkg::CSR_ADDR_W-1:0] SYMBOL_COUNT_ADDR =
      sacs_pkg::CSR_ADDR_W'(4 * int'(sacs_pkg::CSR_SYMBOL_COUNT));

   typedef struct packed {
      logic [sacs_pkg::SCORE_W-1:0] score;
      logic [sacs_pkg::COUNT_W-1:0] count;
      logic                         full;
   } coverage_result_type;

   typedef enum int {
      READY_ALWAYS,
      READY_COIN,
      READY_SPARSE,
      READY_TOGGLE
   } ready_mode_type;

   typedef enum int {
      MASK_ZERO,
      MASK_ONE_HOT,
      MASK_TWO_BITS,
      MASK_SPARSE,
      MASK_IN_RANGE,
      MASK_ANY_BITS
   } mask_kind_type;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_tvalid = 1'b0;
   logic                              req_tready;
   logic [sacs_pkg::REQ_DATA_W-1:0]   req_tdata = '0;    // item_mask[11:0]
   logic                              req_tuser = 1'b0;  // start_sequence
   logic                              rsp_tvalid;
   logic                              rsp_tready = 1'b0;
   // running_score[18:0], covered_count[30:19], all_covered[31]
   logic [sacs_pkg::RSP_DATA_W-1:0]   rsp_tdata;
   logic                              csr_psel = 1'b0;
   logic                              csr_penable = 1'b0;
   logic                              csr_pwrite = 1'b0;
   logic [sacs_pkg::CSR_ADDR_W-1:0]   csr_paddr = '0;
   logic [sacs_pkg::CSR_DATA_W-1:0]   csr_pwdata = '0;
   logic [sacs_pkg::CSR_DATA_W-1:0]   csr_prdata;
   logic                              csr_pready;

   subarray_or_coverage_scorer dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // scorer state
   logic [sacs_pkg::MAX_SYMBOLS-1:0] or_runs [sacs_pkg::LIST_DEPTH];
   int                               run_count;
   logic [sacs_pkg::STAMP_BITS-1:0]  seen_epoch [STORE_SIZE];
   logic [sacs_pkg::STAMP_BITS-1:0]  run_epoch;
   int                               score_acc;
   int                               cover_acc;
   logic [sacs_pkg::K_W-1:0]         k_reg;

   coverage_result_type pending_results [$];
   int                  fail_count;
   int                  cycle_count;
   int                  burst_left;
   int                  hold_off_len;
   int                  hold_left;
   ready_mode_type      ready_mode;
   int                  mode_left;

   function automatic int active_symbols();
      int k;
      k = k_reg;
      if (k < 1) k = 1;
      if (k > sacs_pkg::MAX_SYMBOLS) k = sacs_pkg::MAX_SYMBOLS;
      return k;
   endfunction

   function automatic coverage_result_type score_subarray_ors(
      input logic [sacs_pkg::MAX_SYMBOLS-1:0] mask,
      input logic start);
      int                               k;
      int                               h;
      int                               r;
      int                               n;
      int                               weight;
      logic [sacs_pkg::MAX_SYMBOLS-1:0] kmask;
      logic [sacs_pkg::MAX_SYMBOLS-1:0] value;
      logic [sacs_pkg::MAX_SYMBOLS-1:0] merged;
      logic [sacs_pkg::MAX_SYMBOLS-1:0] next_runs [sacs_pkg::LIST_DEPTH];
      coverage_result_type              res;
      k     = active_symbols();
      h     = k / 2;
      kmask = sacs_pkg::MAX_SYMBOLS'((1 << k) - 1);
      value = mask & kmask;
      if (start) begin
         run_epoch = run_epoch + 1'b1;
         if (run_epoch == '0) begin
            foreach (seen_epoch[i]) seen_epoch[i] = '0;
            run_epoch = sacs_pkg::STAMP_BITS'(1);
         end
         run_count = 0;
         score_acc = 0;
         cover_acc = 0;
      end
      next_runs[0] = value;
      n = 1;
      for (int i = 0; i < run_count; i++) begin
         merged = (or_runs[i] | value) & kmask;
         if (merged != next_runs[n-1] && n < sacs_pkg::LIST_DEPTH) begin
            next_runs[n] = merged;
            n++;
         end
      end
      for (int i = 0; i < n; i++) begin
         if (next_runs[i] != '0 && seen_epoch[next_runs[i]] != run_epoch) begin
            seen_epoch[next_runs[i]] = run_epoch;
            r      = $countones(next_runs[i]);
            weight = int'(sacs_pkg::WEIGHT_BASE);
            if (r == h || (k % 2 == 1 && r == h + 1)) begin
               weight += int'(sacs_pkg::WEIGHT_CENTRAL);
            end
            if (r == h - 1 || r == k - h + 1) weight += int'(sacs_pkg::WEIGHT_NEAR);
            score_acc += weight;
            if (score_acc > int'(sacs_pkg::SCORE_MAX)) score_acc = int'(sacs_pkg::SCORE_MAX);
            if (cover_acc < int'(sacs_pkg::COVER_MAX)) cover_acc++;
         end
         or_runs[i] = next_runs[i];
      end
      run_count = n;
      res.score = sacs_pkg::SCORE_W'(score_acc);
      res.count = (cover_acc > int'(sacs_pkg::COUNT_MAX)) ? sacs_pkg::COUNT_MAX :
                  sacs_pkg::COUNT_W'(cover_acc);
      res.full  = (cover_acc == int'(kmask));
      return res;
   endfunction

   function automatic logic [sacs_pkg::MAX_SYMBOLS-1:0] random_mask();
      int                               k;
      logic [sacs_pkg::MAX_SYMBOLS-1:0] kmask;
      mask_kind_type                    kind;
      k     = active_symbols();
      kmask = sacs_pkg::MAX_SYMBOLS'((1 << k) - 1);
      kind  = mask_kind_type'($urandom_range(int'(MASK_ZERO), int'(MASK_ANY_BITS)));
      case (kind)
         MASK_ZERO:     return '0;
         MASK_ONE_HOT:  return sacs_pkg::MAX_SYMBOLS'(1) << $urandom_range(0, k - 1);
         MASK_TWO_BITS: return (sacs_pkg::MAX_SYMBOLS'(1) << $urandom_range(0, k - 1)) |
                               (sacs_pkg::MAX_SYMBOLS'(1) << $urandom_range(0, k - 1));
         MASK_SPARSE:   return sacs_pkg::MAX_SYMBOLS'($urandom & $urandom & $urandom) &
                               kmask;
         MASK_IN_RANGE: return sacs_pkg::MAX_SYMBOLS'($urandom) & kmask;
         default:       return sacs_pkg::MAX_SYMBOLS'($urandom);
      endcase
   endfunction

   task automatic send_word(input logic [sacs_pkg::MAX_SYMBOLS-1:0] mask,
                            input logic start);
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= sacs_pkg::REQ_DATA_W'(mask);
      req_tuser  <= start;
      do @(posedge clock); while (!req_tready);
      pending_results.insert(pending_results.size(), score_subarray_ors(mask, start));
   endtask

   task automatic send_paced(input logic [sacs_pkg::MAX_SYMBOLS-1:0] mask,
                             input logic start);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 150)
                                                  : $urandom_range(1, 30);
      end
      send_word(mask, start);
      burst_left--;
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_TICKS) @(posedge clock);
   endtask

   // write symbol_count once the block is idle, then read it back
   task automatic set_symbol_count(input logic [sacs_pkg::K_W-1:0] value);
      drain_results();
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= SYMBOL_COUNT_ADDR;
      csr_pwdata  <= sacs_pkg::CSR_DATA_W'(value);
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      k_reg = value;
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== sacs_pkg::CSR_DATA_W'(value)) begin
         $error("symbol_count readback: expected %0d, got %0d", value, csr_prdata);
         fail_count++;
      end
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic test_before_first_start();
      send_paced(12'h0F0, 1'b0);
      send_paced(12'h00F, 1'b0);
      send_paced(12'hF00, 1'b0);
   endtask

   task automatic test_rank_weights();
      send_paced(12'hFFF, 1'b1);
      send_paced(12'h000, 1'b0);
      send_paced(12'h001, 1'b1);
      send_paced(12'h002, 1'b0);
      send_paced(12'h004, 1'b0);
      send_paced(12'h008, 1'b0);
      send_paced(12'h0F0, 1'b0);
   endtask

   task automatic test_symbol_count_extremes();
      set_symbol_count(sacs_pkg::K_W'(1));
      send_paced(12'h001, 1'b1);
      send_paced(12'hFFE, 1'b1);
      set_symbol_count(sacs_pkg::K_W'(0));
      send_paced(12'h001, 1'b1);
      send_paced(12'hFFF, 1'b0);
      set_symbol_count(sacs_pkg::K_W'(15));
      send_paced(12'hFFF, 1'b1);
      send_paced(12'h800, 1'b0);
      set_symbol_count(sacs_pkg::K_W'(sacs_pkg::MAX_SYMBOLS));
      send_paced(12'h555, 1'b1);
      send_paced(12'hAAA, 1'b0);
   endtask

   task automatic test_full_coverage();
      set_symbol_count(sacs_pkg::K_W'(2));
      send_paced(12'h001, 1'b1);
      send_paced(12'h002, 1'b0);
      set_symbol_count(sacs_pkg::K_W'(3));
      send_paced(12'h001, 1'b1);
      send_paced(12'h002, 1'b0);
      send_paced(12'h004, 1'b0);
   endtask

   task automatic test_backpressure();
      set_symbol_count(sacs_pkg::K_W'(6));
      @(posedge clock);
      hold_off_len = 400;
      send_word(random_mask(), 1'b1);
      repeat (39) send_word(random_mask(), 1'b0);
   endtask

   // enough short sequences to roll the stamp epoch over
   task automatic test_epoch_wrap();
      int len;
      set_symbol_count(sacs_pkg::K_W'(3));
      repeat (270) begin
         len = $urandom_range(1, 3);
         send_paced(random_mask(), 1'b1);
         repeat (len - 1) send_paced(random_mask(), 1'b0);
      end
   endtask

   task automatic test_random_sequences();
      logic [sacs_pkg::K_W-1:0] phase_k [10];
      int                       left;
      int                       len;
      phase_k = '{sacs_pkg::K_W'(12), sacs_pkg::K_W'(1), sacs_pkg::K_W'(5),
                  sacs_pkg::K_W'(15), sacs_pkg::K_W'(0), sacs_pkg::K_W'(7),
                  sacs_pkg::K_W'(4), sacs_pkg::K_W'($urandom_range(1, 12)),
                  sacs_pkg::K_W'($urandom_range(2, 6)),
                  sacs_pkg::K_W'($urandom_range(0, 15))};
      foreach (phase_k[p]) begin
         set_symbol_count(phase_k[p]);
         left = 95;
         // sometimes carry the old list into the new symbol count
         send_paced(random_mask(), $urandom_range(0, 4) != 0);
         left--;
         while (left > 0) begin
            if ($urandom_range(0, 9) == 0) begin
               send_paced(sacs_pkg::MAX_SYMBOLS'($urandom), 1'($urandom_range(0, 1)));
               left--;
            end else begin
               len = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80)
                                                 : $urandom_range(2, 15);
               send_paced(random_mask(), 1'b1);
               repeat (len - 1) send_paced(random_mask(), 1'b0);
               left -= len;
            end
         end
      end
   endtask

   always @(negedge clock) begin
      if (hold_off_len != 0) begin
         hold_left    = hold_off_len;
         hold_off_len = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            ready_mode = ready_mode_type'($urandom_range(int'(READY_ALWAYS),
                                                         int'(READY_TOGGLE)));
            mode_left  = $urandom_range(20, 200);
         end
         mode_left--;
         case (ready_mode)
            READY_ALWAYS: rsp_tready <= 1'b1;
            READY_COIN:   rsp_tready <= 1'($urandom_range(0, 1));
            READY_SPARSE: rsp_tready <= ($urandom_range(0, 5) == 0);
            default:      rsp_tready <= ~rsp_tready;
         endcase
      end
   end

   always @(posedge clock) begin
      coverage_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $error("result word with no item waiting: %h", rsp_tdata);
            fail_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_tdata[18:0] !== want.score) begin
               $error("running_score: expected %0d, got %0d", want.score, rsp_tdata[18:0]);
               fail_count++;
            end
            if (rsp_tdata[30:19] !== want.count) begin
               $error("covered_count: expected %0d, got %0d", want.count, rsp_tdata[30:19]);
               fail_count++;
            end
            if (rsp_tdata[31] !== want.full) begin
               $error("all_covered: expected %0d, got %0d", want.full, rsp_tdata[31]);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      foreach (seen_epoch[i]) seen_epoch[i] = '0;
      run_count    = 0;
      run_epoch    = '0;
      score_acc    = 0;
      cover_acc    = 0;
      k_reg        = sacs_pkg::K_W'(8);
      fail_count   = 0;
      cycle_count  = 0;
      burst_left   = 0;
      hold_off_len = 0;
      hold_left    = 0;
      mode_left    = 0;
      ready_mode   = READY_ALWAYS;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_before_first_start();
      test_rank_weights();
      test_symbol_count_extremes();
      test_full_coverage();
      test_backpressure();
      test_epoch_wrap();
      test_random_sequences();
      drain_results();

      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/sacs_pkg.sv
rtl/sacs_ctrl.sv
rtl/sacs_datapath.sv
rtl/subarray_or_coverage_scorer.sv
test/tb_top.sv
